// ===== rtl/partition_split_planner_assert.svh =====
// Assertion macros for the partition split planner.
// Included by the top level; the macros use its clk and rst_n signals.
`ifndef PARTITION_SPLIT_PLANNER_ASSERT_SVH
`define PARTITION_SPLIT_PLANNER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/psp_pkg.sv =====
// Shared types and constants of the partition split planner.
// Used by psp_div and partition_split_planner; depends on nothing else.
`default_nettype none

package psp_pkg;

  localparam int NODE_W     = 16;
  localparam int FRAME_W    = 24;
  localparam int PEN_W      = 42;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FORCED_SPLIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMBALANCE_LIM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAMES     = 2'd2;

  // Register reset values.
  localparam logic [16:0]        IMBALANCE_RESET = 17'd6554;
  localparam logic [NODE_W-1:0]  FRAMES_RESET    = 16'd1000;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_IMBALANCE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_INVALID   = 2'd2;

  // Divider request and response.
  typedef struct packed {
    logic               start;
    logic               short_op;  // dividend fits in 16 bits
    logic [FRAME_W-1:0] dividend;
    logic [NODE_W-1:0]  divisor;
  } psp_div_req_t;

  typedef struct packed {
    logic               done;
    logic [FRAME_W-1:0] quot;
    logic [NODE_W-1:0]  rem;
  } psp_div_res_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV_W = 7'b0000010,
    S_DIV_H = 7'b0000100,
    S_DIV_Q = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_EVAL  = 7'b0100000,
    S_STAT  = 7'b1000000
  } psp_state_t;

endpackage

`default_nettype wire

// ===== rtl/psp_div.sv =====
// Iterative restoring divider, two quotient bits per cycle.
// Depends on psp_pkg for the request and response structs.
`default_nettype none

module psp_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  psp_pkg::psp_div_req_t req,
  output psp_pkg::psp_div_res_t res
);
  import psp_pkg::*;

  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] STEPS_LONG  = CNT_W'(FRAME_W / 2);
  localparam logic [CNT_W-1:0] STEPS_SHORT = CNT_W'(NODE_W / 2);

  typedef struct packed {
    logic [NODE_W-1:0]  rem;
    logic [FRAME_W-1:0] quot;
  } div_acc_t;

  div_acc_t           acc_r, acc_nxt;
  logic [NODE_W-1:0]  dvs_r, dvs_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  function automatic div_acc_t div_step(div_acc_t a, logic [NODE_W-1:0] d);
    logic [NODE_W:0] t;
    div_acc_t        o;
    t = {a.rem, a.quot[FRAME_W-1]};
    if (t >= {1'b0, d}) begin
      o.rem  = NODE_W'(t - {1'b0, d});
      o.quot = {a.quot[FRAME_W-2:0], 1'b1};
    end else begin
      o.rem  = t[NODE_W-1:0];
      o.quot = {a.quot[FRAME_W-2:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    acc_nxt  = acc_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      acc_nxt.rem  = '0;
      acc_nxt.quot = req.short_op ? {req.dividend[NODE_W-1:0], (FRAME_W-NODE_W)'(0)}
                                  : req.dividend;
      dvs_nxt  = req.divisor;
      cnt_nxt  = req.short_op ? STEPS_SHORT : STEPS_LONG;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = div_step(div_step(acc_r, dvs_r), dvs_r);
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    dvs_r <= dvs_nxt;
  end

  assign res.done = done_r;
  assign res.quot = acc_r.quot;
  assign res.rem  = acc_r.rem;

endmodule

`default_nettype wire

// ===== rtl/partition_split_planner.sv =====
// Partition split planner: top level with the search sequencer and shared multiplier.
// Depends on psp_pkg, psp_div and partition_split_planner_assert.svh.
//
//   channel  ports                          handshake
//   input    in_node_count/row/frame        start high while busy low
//   result   out_best_split ... out_status  out_valid, one cycle, no stall
//   config   cfg_index, cfg_data            cfg_we, taken at once
//
// A word whose counts are zero, or whose forced split exceeds the node count, is
// answered in the cycle after it is taken and the block stays free.
// Otherwise each candidate split takes three passes through the shared
// two-bit-per-cycle divider (width, height and rows per group), a multiply
// step and one compare. Busy stays high through the run and falls in the
// same cycle that the result is shown; a search cut short by the frame limit
// ends its last candidate after the height division.
// Reset is synchronous and active low; it restores the register defaults.
// The receiver cannot stall: each result word is shown for exactly one cycle.
`default_nettype none

module partition_split_planner (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [psp_pkg::NODE_W-1:0]     in_node_count,
  input  logic [psp_pkg::NODE_W-1:0]     in_row_count,
  input  logic [psp_pkg::FRAME_W-1:0]    in_frame_count,
  output logic                           out_valid,
  output logic [psp_pkg::NODE_W-1:0]     out_best_split,
  output logic [psp_pkg::NODE_W-1:0]     out_column_width,
  output logic [psp_pkg::PEN_W-1:0]      out_idle_penalty,
  output logic [psp_pkg::STATUS_W-1:0]   out_status,
  input  logic                           cfg_we,
  input  logic [psp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import psp_pkg::*;

  localparam int PROD_W = NODE_W + FRAME_W + 1;   // 16 x 25 multiplier
  localparam int PQ_W   = NODE_W + FRAME_W;       // rows times frames
  localparam int LIM_W  = PQ_W + 17;              // limit times rows times frames
  localparam int CNT_W  = 3;

  // Configuration registers.
  logic [NODE_W-1:0] forced_r;
  logic [16:0]       lim_r;
  logic [NODE_W-1:0] maxf_r;

  // Sequencer state and the latched word.
  psp_state_t          state_r, state_nxt;
  logic [NODE_W-1:0]   nn_r, nn_nxt, nq_r, nq_nxt;
  logic [FRAME_W-1:0]  nf_r, nf_nxt;
  logic [NODE_W-1:0]   s_r, s_nxt, top_r, top_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  // Per-candidate terms.
  logic [NODE_W-1:0]   w_r, w_nxt;
  logic [NODE_W-1:0]   node_idle_r, node_idle_nxt;
  logic [FRAME_W-1:0]  h_nxt;
  logic [NODE_W-1:0]   col_idle_r, col_idle_nxt;
  logic [NODE_W-1:0]   rows_per_r, rows_per_nxt;
  logic [NODE_W-1:0]   nqmod_r, nqmod_nxt;
  logic [PEN_W-1:0]    acc_r, acc_nxt;

  // Best split so far and the imbalance bound.
  logic [PEN_W-1:0]    best_pen_r, best_pen_nxt;
  logic [NODE_W-1:0]   best_split_r, best_split_nxt;
  logic [NODE_W-1:0]   best_w_r, best_w_nxt;
  logic [PQ_W-1:0]     pq_r, pq_nxt;
  logic [LIM_W-1:0]    lim_acc_r, lim_acc_nxt;

  // Shared multiplier.
  logic [NODE_W-1:0]   mul_a;
  logic [FRAME_W:0]    mul_b;
  logic [PROD_W-1:0]   prod_r;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]   out_split_r, out_split_nxt;
  logic [NODE_W-1:0]   out_width_r, out_width_nxt;
  logic [PEN_W-1:0]    out_pen_r, out_pen_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  psp_div_req_t        div_req;
  psp_div_res_t        div_res;

  logic                accept;
  logic                bad_word;
  logic                take;

  psp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign bad_word = (in_node_count == '0) || (in_row_count == '0) ||
                    (in_frame_count == '0) || (forced_r > in_node_count);
  // A forced split and the first split of a search are always kept; later
  // candidates replace the best one on a tie, so the higher split wins.
  assign take     = (forced_r != '0) || (s_r == NODE_W'(1)) || (acc_r <= best_pen_r);

  // Configuration writes; the user keeps the block idle whenever they come, as the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      forced_r <= '0;
      lim_r    <= IMBALANCE_RESET;
      maxf_r   <= FRAMES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FORCED_SPLIT:  forced_r <= cfg_data[NODE_W-1:0];
        CFG_IMBALANCE_LIM: lim_r    <= cfg_data;
        CFG_MAX_FRAMES:    maxf_r   <= cfg_data[NODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Operand selection for the shared multiplier. While the penalty is built it
  // forms rows*col_idle, rows_per*node_idle and (rows mod s)*(w*h), with w*h
  // written as frames + col_idle. The status pass forms rows*frames and then the
  // limit times that product in two halves.
  always_comb begin
    mul_a = nqmod_r;
    mul_b = {1'b0, nf_r} + {(FRAME_W+1-NODE_W)'(0), col_idle_r};
    case (state_r)
      S_MUL: begin
        case (cnt_r)
          CNT_W'(0): begin
            mul_a = nq_r;
            mul_b = {(FRAME_W+1-NODE_W)'(0), col_idle_r};
          end
          CNT_W'(1): begin
            mul_a = rows_per_r;
            mul_b = {(FRAME_W+1-NODE_W)'(0), node_idle_r};
          end
          default: ;
        endcase
      end
      S_STAT: begin
        case (cnt_r)
          CNT_W'(0): begin
            mul_a = nq_r;
            mul_b = {1'b0, nf_r};
          end
          CNT_W'(2): begin
            mul_a = lim_r[NODE_W-1:0];
            mul_b = pq_r[FRAME_W:0];
          end
          default: begin
            mul_a = lim_r[NODE_W-1:0];
            mul_b = {(FRAME_W+1-(PQ_W-FRAME_W-1))'(0), pq_r[PQ_W-1:FRAME_W+1]};
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    nn_nxt         = nn_r;
    nq_nxt         = nq_r;
    nf_nxt         = nf_r;
    s_nxt          = s_r;
    top_nxt        = top_r;
    cnt_nxt        = cnt_r;
    w_nxt          = w_r;
    node_idle_nxt  = node_idle_r;
    col_idle_nxt   = col_idle_r;
    rows_per_nxt   = rows_per_r;
    nqmod_nxt      = nqmod_r;
    acc_nxt        = acc_r;
    best_pen_nxt   = best_pen_r;
    best_split_nxt = best_split_r;
    best_w_nxt     = best_w_r;
    pq_nxt         = pq_r;
    lim_acc_nxt    = lim_acc_r;
    out_valid_nxt  = 1'b0;
    out_split_nxt  = out_split_r;
    out_width_nxt  = out_width_r;
    out_pen_nxt    = out_pen_r;
    out_status_nxt = out_status_r;
    h_nxt          = div_res.quot + FRAME_W'(div_res.rem != '0);

    div_req.start    = 1'b0;
    div_req.short_op = 1'b1;
    div_req.dividend = {(FRAME_W-NODE_W)'(0), nn_r};
    div_req.divisor  = s_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (bad_word) begin
            out_valid_nxt  = 1'b1;
            out_split_nxt  = '0;
            out_width_nxt  = '0;
            out_pen_nxt    = '0;
            out_status_nxt = STAT_INVALID;
          end else begin
            nn_nxt  = in_node_count;
            nq_nxt  = in_row_count;
            nf_nxt  = in_frame_count;
            top_nxt = (in_node_count < in_row_count) ? in_node_count : in_row_count;
            s_nxt   = (forced_r != '0) ? forced_r : NODE_W'(1);
            // Width of the groups: nodes / split.
            div_req.start    = 1'b1;
            div_req.dividend = {(FRAME_W-NODE_W)'(0), in_node_count};
            div_req.divisor  = s_nxt;
            state_nxt        = S_DIV_W;
          end
        end
      end

      S_DIV_W: begin
        if (div_res.done) begin
          w_nxt         = div_res.quot[NODE_W-1:0];
          node_idle_nxt = div_res.rem;   // nodes left over, nodes - w*s
          // Column height: frames / width, rounded up.
          div_req.start    = 1'b1;
          div_req.short_op = 1'b0;
          div_req.dividend = nf_r;
          div_req.divisor  = div_res.quot[NODE_W-1:0];
          state_nxt        = S_DIV_H;
        end
      end

      S_DIV_H: begin
        if (div_res.done) begin
          // Idle slots in a column: h*w - frames, which is w minus the remainder
          // when the division does not come out even.
          col_idle_nxt = (div_res.rem != '0) ? (w_r - div_res.rem) : '0;
          if ((forced_r == '0) && (s_r != NODE_W'(1)) &&
              (h_nxt > {(FRAME_W-NODE_W)'(0), maxf_r})) begin
            // Columns grew too tall: the search ends with the best so far.
            cnt_nxt   = '0;
            state_nxt = S_STAT;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = {(FRAME_W-NODE_W)'(0), nq_r};
            div_req.divisor  = s_r;
            state_nxt        = S_DIV_Q;
          end
        end
      end

      S_DIV_Q: begin
        if (div_res.done) begin
          rows_per_nxt = div_res.quot[NODE_W-1:0] + NODE_W'(div_res.rem != '0);
          nqmod_nxt    = div_res.rem;
          cnt_nxt      = '0;
          state_nxt    = S_MUL;
        end
      end

      S_MUL: begin
        // Each product is registered and arrives in the cycle after its operands; sum the three terms.
        acc_nxt = (cnt_r == '0) ? '0 : (acc_r + PEN_W'(prod_r));
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(3)) begin
          state_nxt = S_EVAL;
        end
      end

      S_EVAL: begin
        if (take) begin
          best_pen_nxt   = acc_r;
          best_split_nxt = s_r;
          best_w_nxt     = w_r;
        end
        if ((forced_r != '0) || (s_r >= top_r)) begin
          cnt_nxt   = '0;
          state_nxt = S_STAT;
        end else begin
          s_nxt            = s_r + 1'b1;
          div_req.start    = 1'b1;
          div_req.divisor  = s_nxt;
          state_nxt        = S_DIV_W;
        end
      end

      S_STAT: begin
        // Imbalance test, exact: penalty * 65536 > limit * frames * rows.
        cnt_nxt = cnt_r + 1'b1;
        case (cnt_r)
          CNT_W'(1): pq_nxt = prod_r[PQ_W-1:0];
          CNT_W'(3): lim_acc_nxt = LIM_W'(prod_r) +
                                   (lim_r[16] ? LIM_W'({pq_r, 16'b0}) : '0);
          CNT_W'(4): lim_acc_nxt = lim_acc_r + LIM_W'({prod_r, (FRAME_W+1)'(0)});
          CNT_W'(5): begin
            out_valid_nxt  = 1'b1;
            out_split_nxt  = best_split_r;
            out_width_nxt  = (nf_r < {(FRAME_W-NODE_W)'(0), nn_r}) ?
                             nf_r[NODE_W-1:0] : best_w_r;
            out_pen_nxt    = best_pen_r;
            out_status_nxt = ({best_pen_r, 16'b0} > {1'b0, lim_acc_r}) ?
                             STAT_IMBALANCE : STAT_OK;
            state_nxt      = S_IDLE;
          end
          default: ;
        endcase
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nn_r         <= nn_nxt;
    nq_r         <= nq_nxt;
    nf_r         <= nf_nxt;
    s_r          <= s_nxt;
    top_r        <= top_nxt;
    w_r          <= w_nxt;
    node_idle_r  <= node_idle_nxt;
    col_idle_r   <= col_idle_nxt;
    rows_per_r   <= rows_per_nxt;
    nqmod_r      <= nqmod_nxt;
    acc_r        <= acc_nxt;
    best_pen_r   <= best_pen_nxt;
    best_split_r <= best_split_nxt;
    best_w_r     <= best_w_nxt;
    pq_r         <= pq_nxt;
    lim_acc_r    <= lim_acc_nxt;
    out_split_r  <= out_split_nxt;
    out_width_r  <= out_width_nxt;
    out_pen_r    <= out_pen_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_best_split   = out_split_r;
  assign out_column_width = out_width_r;
  assign out_idle_penalty = out_pen_r;
  assign out_status       = out_status_r;

  // Every taken word leads to either a running search or an answer next cycle.
  `include "partition_split_planner_assert.svh"

  `PSP_ASSERT_NXT(a_accept_progress, start && !busy, busy || out_valid,
                  "accepted word neither started nor answered")
  `PSP_ASSERT_IMP(a_result_when_free, out_valid, !busy,
                  "result shown while a search is still running")
  `PSP_ASSERT_IMP(a_ok_result_nonzero, out_valid && (out_status != STAT_INVALID),
                  (out_best_split != '0) && (out_column_width != '0),
                  "valid plan with zero split or zero width")

endmodule

`default_nettype wire

// ===== tb/partition_split_planner_tb.sv =====
// Self-checking testbench for the partition split planner.
// Depends on psp_pkg and the partition_split_planner RTL; drives the block with
// directed and random count words under several register settings.
module partition_split_planner_tb;
  import psp_pkg::*;

  // One input word: the three counts the planner works from.
  typedef struct packed {
    logic [NODE_W-1:0]  nodes;
    logic [NODE_W-1:0]  rows;
    logic [FRAME_W-1:0] frames;
  } count_word_t;

  // One result word as the planner should report it.
  typedef struct packed {
    logic [NODE_W-1:0]   split;
    logic [NODE_W-1:0]   width;
    logic [PEN_W-1:0]    penalty;
    logic [STATUS_W-1:0] status;
  } split_plan_t;

  // Each candidate split adds to the block's run time, so random words
  // are kept to short searches. A couple of words may run a much deeper search.
  localparam int unsigned SEARCH_CAP = 150;
  localparam int unsigned DEEP_CAP   = 2500;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  start          = 1'b0;
  logic [NODE_W-1:0]     in_node_count  = '0;
  logic [NODE_W-1:0]     in_row_count   = '0;
  logic [FRAME_W-1:0]    in_frame_count = '0;
  logic                  cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = CFG_FORCED_SPLIT;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;

  logic                busy;
  logic                out_valid;
  logic [NODE_W-1:0]   out_best_split;
  logic [NODE_W-1:0]   out_column_width;
  logic [PEN_W-1:0]    out_idle_penalty;
  logic [STATUS_W-1:0] out_status;

  // Our copy of the block's registers, starting from their reset values.
  logic [15:0] forced_split_r = 16'd0;
  logic [16:0] limit_r        = IMBALANCE_RESET;
  logic [15:0] frame_cap_r    = FRAMES_RESET;

  count_word_t word_q[$];  // words waiting to be sent
  split_plan_t plan_q[$];  // plans predicted for words already taken

  int unsigned mismatches = 0;
  int unsigned taken      = 0;
  int unsigned deep_left  = 2;
  int unsigned gap_left   = 0;
  int unsigned burst_left = 0;
  bit          drain_wait = 1'b0;

  always #2 clk = ~clk;

  partition_split_planner dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_node_count    (in_node_count),
    .in_row_count     (in_row_count),
    .in_frame_count   (in_frame_count),
    .out_valid        (out_valid),
    .out_best_split   (out_best_split),
    .out_column_width (out_column_width),
    .out_idle_penalty (out_idle_penalty),
    .out_status       (out_status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  function automatic longint unsigned ceil_div(input longint unsigned a,
                                               input longint unsigned b);
    return a / b + 64'((a % b) != 0);
  endfunction

  // Idle work slots when nn nodes are cut into s groups; needs 1 <= s <= nn.
  // The three terms are the padding of each column, the nodes left over by
  // the integer split, and the extra row pass when rows do not divide evenly.
  function automatic longint unsigned idle_slots(input longint unsigned nq,
                                                 input longint unsigned nf,
                                                 input longint unsigned nn,
                                                 input longint unsigned s);
    longint unsigned w;
    longint unsigned h;
    w = nn / s;
    h = ceil_div(nf, w);
    return nq * (h * w - nf) + ceil_div(nq, s) * (nn - w * s) + (nq % s) * (w * h);
  endfunction

  // Works out the plan for one word under the current registers. tried counts
  // the candidate splits looked at, which tells how long the block will take.
  function automatic split_plan_t plan_split(input count_word_t cw,
                                             output int unsigned tried);
    longint unsigned nn, nq, nf, top, s, wd, h, p, best, width, split;
    split_plan_t r;
    nn    = 64'(cw.nodes);
    nq    = 64'(cw.rows);
    nf    = 64'(cw.frames);
    tried = 0;
    r     = '0;
    // A zero count, or a forced split above the node count, is refused.
    if (nn == 0 || nq == 0 || nf == 0 || 64'(forced_split_r) > nn) begin
      r.status = STAT_INVALID;
      return r;
    end
    if (forced_split_r == 0) begin
      // Split one is always the starting point and is never held against
      // the frame limit. Later splits replace it on equal or lower penalty.
      top   = (nn < nq) ? nn : nq;
      split = 1;
      width = nn;
      best  = idle_slots(nq, nf, nn, 1);
      tried = 1;
      for (s = 2; s <= top; s++) begin
        wd = nn / s;
        h  = ceil_div(nf, wd);
        tried++;
        if (h > 64'(frame_cap_r)) break;
        p = idle_slots(nq, nf, nn, s);
        if (p <= best) begin
          best  = p;
          split = s;
          width = wd;
        end
      end
    end else begin
      split = 64'(forced_split_r);
      width = nn / split;
      best  = idle_slots(nq, nf, nn, split);
      tried = 1;
    end
    // With fewer frames than nodes the reported width is the frame count.
    if (nf < nn) width = nf;
    r.split   = split[NODE_W-1:0];
    r.width   = width[NODE_W-1:0];
    r.penalty = best[PEN_W-1:0];
    // Exact test of penalty / (frames * rows) > limit / 65536.
    r.status  = ((best << 16) > (64'(limit_r) * nf * nq)) ? STAT_IMBALANCE : STAT_OK;
    return r;
  endfunction

  task automatic report_error(input string msg);
    if (mismatches < 40) $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // One count field: mostly small, sometimes medium, now and then a full-width
  // random value, all ones, or zero.
  function automatic longint unsigned draw_count(input int unsigned bits,
                                                 input int unsigned small_top);
    longint unsigned mask;
    mask = (64'd1 << bits) - 1;
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return mask;
      2, 3, 4: return 64'($urandom) & mask;
      5, 6, 7: return 64'($urandom_range(1, 4096));
      default: return 64'($urandom_range(1, small_top));
    endcase
  endfunction

  function automatic count_word_t random_word();
    count_word_t cw;
    int unsigned span;
    cw.nodes  = NODE_W'(draw_count(NODE_W, 48));
    // With a forced split most words carry enough nodes to use it.
    if (forced_split_r != 0 && $urandom_range(0, 3) != 0) begin
      span     = 32'(16'hFFFF - forced_split_r);
      if (span > 40) span = 40;
      cw.nodes = forced_split_r + NODE_W'($urandom_range(0, span));
    end
    cw.rows   = NODE_W'(draw_count(NODE_W, 64));
    cw.frames = FRAME_W'(draw_count(FRAME_W, 300));
    return cw;
  endfunction

  // Queues n random words, redrawing any whose search would run too long.
  task automatic queue_random(input int unsigned n);
    count_word_t cw;
    split_plan_t p;
    int unsigned tried;
    repeat (n) begin
      do begin
        cw = random_word();
        p  = plan_split(cw, tried);
      end while (tried > SEARCH_CAP && !(deep_left != 0 && tried <= DEEP_CAP));
      if (tried > SEARCH_CAP) deep_left--;
      word_q = {word_q, cw};
    end
  endtask

  task automatic push_word(input logic [NODE_W-1:0] nn, input logic [NODE_W-1:0] nq,
                           input logic [FRAME_W-1:0] nf);
    count_word_t cw;
    cw.nodes  = nn;
    cw.rows   = nq;
    cw.frames = nf;
    word_q = {word_q, cw};
  endtask

  // Returns once every queued word has been taken, every plan has come back
  // and the block has dropped busy.
  task automatic wait_idle();
    while (word_q.size() != 0 || start || plan_q.size() != 0 || busy !== 1'b0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_FORCED_SPLIT:  forced_split_r = val[15:0];
      CFG_IMBALANCE_LIM: limit_r        = val;
      CFG_MAX_FRAMES:    frame_cap_r    = val[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Registers only change while the block sits idle.
  task automatic set_config(input logic [15:0] forced, input logic [16:0] lim,
                            input logic [15:0] frame_cap);
    wait_idle();
    write_reg(CFG_FORCED_SPLIT, CFG_DATA_W'(forced));
    write_reg(CFG_IMBALANCE_LIM, lim);
    write_reg(CFG_MAX_FRAMES, CFG_DATA_W'(frame_cap));
  endtask

  // Driver. A word is taken at an edge where start is high and busy is low;
  // its plan is predicted right then, with the registers in force. After each
  // word the driver may idle for a random gap, and now and then it holds off
  // until every outstanding plan has come back.
  always @(posedge clk) begin
    split_plan_t plan;
    int unsigned tried;
    int unsigned pick;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        plan = plan_split(word_q.pop_front(), tried);
        plan_q = {plan_q, plan};
        taken++;
        if (burst_left != 0) begin
          burst_left--;
          gap_left = 0;
        end else begin
          pick = $urandom_range(0, 9);
          case (pick)
            0, 1, 2, 3, 4: gap_left = 0;
            5, 6, 7:       gap_left = $urandom_range(1, 3);
            8:             gap_left = $urandom_range(4, 12);
            default:       gap_left = $urandom_range(20, 150);
          endcase
          if ($urandom_range(0, 11) == 0) burst_left = $urandom_range(6, 20);
        end
        if (taken % 20 == 7 || $urandom_range(0, 29) == 0) drain_wait = 1'b1;
      end else if (gap_left != 0) begin
        gap_left--;
      end
      if (drain_wait && plan_q.size() == 0) drain_wait = 1'b0;
      if (drain_wait || gap_left != 0 || word_q.size() == 0) begin
        start <= 1'b0;
      end else begin
        start          <= 1'b1;
        in_node_count  <= word_q[0].nodes;
        in_row_count   <= word_q[0].rows;
        in_frame_count <= word_q[0].frames;
      end
    end
  end

  // Monitor. A result word lasts one cycle and cannot be held off, so it is
  // sampled at the edge that ends that cycle and checked against the oldest
  // predicted plan.
  always @(posedge clk) begin
    split_plan_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (plan_q.size() == 0) begin
        report_error($sformatf("result word with no plan pending (split %0d)",
                               out_best_split));
      end else begin
        want = plan_q.pop_front();
        if (out_best_split !== want.split)
          report_error($sformatf("best_split %0d, expected %0d", out_best_split,
                                 want.split));
        if (out_column_width !== want.width)
          report_error($sformatf("column_width %0d, expected %0d", out_column_width,
                                 want.width));
        if (out_idle_penalty !== want.penalty)
          report_error($sformatf("idle_penalty %0d, expected %0d", out_idle_penalty,
                                 want.penalty));
        if (out_status !== want.status)
          report_error($sformatf("status %0d, expected %0d", out_status, want.status));
      end
    end
  end

  // Stimulus, phase by phase.
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: search enabled, limit near 0.1, frame limit 1000.
    push_word(1, 1, 1);
    push_word(16'hFFFF, 16'hFFFF, 24'hFFFFFF);
    push_word(0, 5, 5);
    push_word(5, 0, 5);
    push_word(5, 5, 0);
    push_word(0, 0, 0);
    push_word(12, 30, 100);
    push_word(7, 3, 2);                       // fewer frames than nodes
    push_word(16'hFFFF, 1, 24'hFFFFFF);       // one row leaves only split one
    push_word(300, 300, 299);                 // long search with many ties
    push_word(64, 16'hFFFF, 16'hFFFF);        // frame limit hit at split two
    push_word(48, 1000, 47);
    queue_random(20);

    // Forced split of three with a zero limit: any idle slot is an imbalance.
    set_config(16'd3, 17'd0, 16'hFFFF);
    push_word(2, 5, 5);                       // forced split above node count
    push_word(3, 7, 10);                      // forced split equal to node count
    push_word(16'hFFFF, 16'hFFFF, 24'hFFFFFF);
    push_word(3, 3, 1);
    queue_random(12);

    // Zero frame limit stops every search at split one; limit above one.
    set_config(16'd0, 17'h1FFFF, 16'd0);
    push_word(16'hFFFF, 16'hFFFF, 1);
    push_word(40, 40, 40);
    queue_random(10);

    // Largest forced split: only a full node count is valid.
    set_config(16'hFFFF, 17'd65536, 16'd1);
    push_word(16'hFFFF, 9, 5);
    push_word(16'hFFFE, 9, 5);
    queue_random(10);

    set_config(16'd1, 17'd65536, 16'd1);
    queue_random(8);

    repeat (3) begin
      set_config($urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 32)),
                 17'($urandom_range(0, 17'h1FFFF)),
                 $urandom_range(0, 3) == 0 ? 16'($urandom_range(1, 65535))
                                           : 16'($urandom_range(1, 40)));
      queue_random(10);
    end

    // Widest frame limit: only words with short searches get through.
    set_config(16'd0, 17'd6554, 16'hFFFF);
    queue_random(10);

    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && plan_q.size() == 0) begin
      $display("PASS partition_split_planner");
    end else begin
      $display("FAIL partition_split_planner");
    end
    $finish;
  end

  // The slowest correct run ends well before this watchdog fires.
  initial begin
    #24000000;
    $display("FAIL partition_split_planner");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/psp_pkg.sv
rtl/psp_div.sv
rtl/partition_split_planner.sv
tb/partition_split_planner_tb.sv
